[design/psc_pkg.sv]
package psc_pkg;

    localparam int unsigned PADDR_W    = 5;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned RAW_W      = 24;
    localparam int unsigned COEFF_W    = 16;
    localparam int unsigned TEMP_OUT_W = 19;
    localparam int unsigned PRES_OUT_W = 32;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_MODEL_SELECT     = 3'd0;
    localparam logic [2:0] REG_SENS_COEFF       = 3'd1;
    localparam logic [2:0] REG_OFF_COEFF        = 3'd2;
    localparam logic [2:0] REG_SENS_TEMP_COEFF  = 3'd3;
    localparam logic [2:0] REG_OFF_TEMP_COEFF   = 3'd4;
    localparam logic [2:0] REG_REF_TEMP_COEFF   = 3'd5;
    localparam logic [2:0] REG_TEMP_SLOPE_COEFF = 3'd6;

    localparam logic signed [TEMP_OUT_W-1:0] TEMP_SAT_HIGH = 19'sd140000;
    localparam logic signed [TEMP_OUT_W-1:0] TEMP_SAT_LOW  = -19'sd140000;

    typedef struct packed {
        logic               model_select;
        logic [COEFF_W-1:0] sens_coeff;
        logic [COEFF_W-1:0] off_coeff;
        logic [COEFF_W-1:0] sens_temp_coeff;
        logic [COEFF_W-1:0] off_temp_coeff;
        logic [COEFF_W-1:0] ref_temp_coeff;
        logic [COEFF_W-1:0] temp_slope_coeff;
    } psc_cfg_t;

    // Signed division by 2^k that truncates toward zero.
    function automatic logic signed [63:0] div_pow2(input logic signed [63:0] v,
                                                    input logic [5:0] k);
        logic signed [63:0] bias;
        bias = v[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
        return (v + bias) >>> k;
    endfunction

endpackage

[design/pressure_sensor_compensation_core.sv]
// Pressure sensor compensation core.
// The s_ channel carries one transaction per raw conversion pair (pressure and
// temperature). For each one, the m_ channel returns exactly one transaction
// with the compensated temperature in hundredths of a degree Celsius and the
// compensated pressure in whole mbar, in the order the inputs were taken.
// The six calibration words and the model select live in an APB register file.
// They must only be written while no transaction is in flight.
// The datapath is a ten-stage pipeline. A result passes through the stage
// registers s1 to s9 and then the output register before it is presented on
// m_valid. One transaction is accepted every cycle while the receiver keeps
// m_ready high, so the sustained rate is then one item per clock.
// Each stage has its own valid bit and moves forward when the stage after it
// is empty or moving. When the receiver holds m_ready low, the pipeline fills
// up behind the output register and s_ready then drops. No data is lost or
// repeated while stalled.
// Reset (synchronous, aresetn low) empties every stage and clears all the
// configuration registers to zero. Payload registers are not reset.
module pressure_sensor_compensation_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Input channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [psc_pkg::RAW_W-1:0]              s_raw_pressure,
    input  logic [psc_pkg::RAW_W-1:0]              s_raw_temperature,
    // Result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [psc_pkg::TEMP_OUT_W-1:0]  m_temperature_centi,
    output logic signed [psc_pkg::PRES_OUT_W-1:0]  m_pressure_mbar,
    // Configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [psc_pkg::PADDR_W-1:0]            paddr,
    input  logic [psc_pkg::APB_DATA_W-1:0]         pwdata,
    output logic [psc_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready
);
    import psc_pkg::*;

    localparam int unsigned NUM_STAGES = 10;

    localparam logic signed [20:0] TEMP_BASE       = 21'sd2000;
    localparam logic signed [20:0] TEMP_VLOW_BASE  = -21'sd1500;
    localparam logic signed [20:0] TEMP_VLOW_LIMIT = -21'sd1600;
    localparam logic [31:0]        RECIP_10        = 32'hCCCC_CCCD;
    localparam logic [31:0]        RECIP_100       = 32'h51EB_851F;

    // Configuration registers.
    psc_cfg_t cfg;
    logic     two_bar;

    psc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready  = 1'b1;
    assign two_bar = cfg.model_select;

    // Pipeline control. A stage may load when it is empty or when the stage
    // after it is moving on in the same cycle.
    logic [NUM_STAGES:1] vld_reg;
    logic [NUM_STAGES:1] vld_next;
    logic [NUM_STAGES:1] stage_adv;

    always_comb begin
        stage_adv[NUM_STAGES] = !vld_reg[NUM_STAGES] || m_ready;
        for (int i = NUM_STAGES - 1; i >= 1; i--) begin
            stage_adv[i] = !vld_reg[i] || stage_adv[i+1];
        end
        vld_next[1] = stage_adv[1] ? s_valid : vld_reg[1];
        for (int i = 2; i <= NUM_STAGES; i++) begin
            vld_next[i] = stage_adv[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = stage_adv[1];
    assign m_valid = vld_reg[NUM_STAGES];

    // Stage 1: temperature difference and the four products that use it.
    logic signed [25:0] dt;
    logic signed [16:0] slope_s;
    logic signed [16:0] sens_tc_s;
    logic signed [16:0] off_tc_s;
    logic signed [51:0] dt_sq_full;

    logic [RAW_W-1:0]   s1_d1_reg;
    logic signed [42:0] s1_temp_prod_reg,  s1_temp_prod_next;
    logic signed [42:0] s1_sens_prod_reg,  s1_sens_prod_next;
    logic signed [42:0] s1_off_prod_reg,   s1_off_prod_next;
    logic [47:0]        s1_dt_sq_reg,      s1_dt_sq_next;

    assign dt = $signed({2'b00, s_raw_temperature})
              - $signed({2'b00, cfg.ref_temp_coeff, 8'h00});
    assign slope_s   = $signed({1'b0, cfg.temp_slope_coeff});
    assign sens_tc_s = $signed({1'b0, cfg.sens_temp_coeff});
    assign off_tc_s  = $signed({1'b0, cfg.off_temp_coeff});

    assign s1_temp_prod_next = dt * slope_s;
    assign s1_sens_prod_next = dt * sens_tc_s;
    assign s1_off_prod_next  = dt * off_tc_s;
    assign dt_sq_full        = dt * dt;
    assign s1_dt_sq_next     = dt_sq_full[47:0];

    // Stage 2: first-order temperature, sensitivity and offset.
    logic [RAW_W-1:0]   s2_d1_reg;
    logic [47:0]        s2_dt_sq_reg;
    logic signed [20:0] s2_temp_reg, s2_temp_next;
    logic signed [35:0] s2_sens_reg, s2_sens_next;
    logic signed [36:0] s2_off_reg,  s2_off_next;

    assign s2_temp_next = 21'(div_pow2(64'(s1_temp_prod_reg), 6'd23)) + TEMP_BASE;

    always_comb begin
        if (two_bar) begin
            s2_sens_next = $signed({4'b0, cfg.sens_coeff, 16'h0000})
                         + 36'(div_pow2(64'(s1_sens_prod_reg), 6'd7));
            s2_off_next  = $signed({4'b0, cfg.off_coeff, 17'h00000})
                         + 37'(div_pow2(64'(s1_off_prod_reg), 6'd6));
        end else begin
            s2_sens_next = $signed({5'b0, cfg.sens_coeff, 15'h0000})
                         + 36'(div_pow2(64'(s1_sens_prod_reg), 6'd8));
            s2_off_next  = $signed({5'b0, cfg.off_coeff, 16'h0000})
                         + 37'(div_pow2(64'(s1_off_prod_reg), 6'd7));
        end
    end

    // Stage 3: squared deviations, range flags and the temperature correction.
    logic signed [20:0] dev_base;
    logic signed [20:0] vl_base;
    logic signed [41:0] dev_full;
    logic signed [41:0] vl_full;
    logic [51:0]        dt_sq_w;
    logic [51:0]        dt_sq_x3;
    logic [51:0]        dt_sq_x11;

    logic [RAW_W-1:0]   s3_d1_reg;
    logic signed [20:0] s3_temp_reg;
    logic signed [35:0] s3_sens_reg;
    logic signed [36:0] s3_off_reg;
    logic [37:0]        s3_dev_reg,  s3_dev_next;
    logic [37:0]        s3_vl_reg,   s3_vl_next;
    logic               s3_low_reg,  s3_low_next;
    logic               s3_vlow_reg, s3_vlow_next;
    logic [16:0]        s3_ti_reg,   s3_ti_next;

    assign dev_base     = s2_temp_reg - TEMP_BASE;
    assign vl_base      = s2_temp_reg - TEMP_VLOW_BASE;
    assign dev_full     = dev_base * dev_base;
    assign vl_full      = vl_base * vl_base;
    assign s3_dev_next  = dev_full[37:0];
    assign s3_vl_next   = vl_full[37:0];
    // Truncated division by 100 below 20 is the same as temp below 2000, and
    // below -15 the same as temp at or below -1600.
    assign s3_low_next  = s2_temp_reg < TEMP_BASE;
    assign s3_vlow_next = s2_temp_reg <= TEMP_VLOW_LIMIT;

    assign dt_sq_w   = 52'(s2_dt_sq_reg);
    assign dt_sq_x3  = (dt_sq_w << 1) + dt_sq_w;
    assign dt_sq_x11 = (dt_sq_w << 3) + (dt_sq_w << 1) + dt_sq_w;

    always_comb begin
        if (two_bar) begin
            s3_ti_next = s3_low_next ? 17'(dt_sq_x11 >> 35) : 17'd0;
        end else begin
            s3_ti_next = s3_low_next ? 17'(dt_sq_x3 >> 33) : 17'(dt_sq_w >> 36);
        end
    end

    // Stage 4: second-order offset and sensitivity terms, final temperature.
    logic [43:0]        dev_w;
    logic [43:0]        vl_w;
    logic [43:0]        offi;
    logic [43:0]        sensi;
    logic signed [21:0] t_raw;

    logic [RAW_W-1:0]            s4_d1_reg;
    logic signed [43:0]          s4_sens_reg, s4_sens_next;
    logic signed [43:0]          s4_off_reg,  s4_off_next;
    logic signed [TEMP_OUT_W-1:0] s4_temp_reg, s4_temp_next;

    assign dev_w = 44'(s3_dev_reg);
    assign vl_w  = 44'(s3_vl_reg);

    always_comb begin
        offi  = '0;
        sensi = '0;
        if (two_bar) begin
            if (s3_low_reg) begin
                offi  = ((dev_w << 5) - dev_w) >> 3;
                sensi = ((dev_w << 6) - dev_w) >> 5;
            end
        end else if (s3_low_reg) begin
            offi  = ((dev_w << 1) + dev_w) >> 1;
            sensi = ((dev_w << 2) + dev_w) >> 3;
            if (s3_vlow_reg) begin
                offi  = offi + ((vl_w << 3) - vl_w);
                sensi = sensi + (vl_w << 2);
            end
        end else begin
            offi = dev_w >> 4;
        end
    end

    assign s4_sens_next = 44'(s3_sens_reg) - $signed(sensi);
    assign s4_off_next  = 44'(s3_off_reg) - $signed(offi);
    assign t_raw        = 22'(s3_temp_reg) - $signed({5'b0, s3_ti_reg});

    always_comb begin
        if (t_raw > 22'(TEMP_SAT_HIGH)) begin
            s4_temp_next = TEMP_SAT_HIGH;
        end else if (t_raw < 22'(TEMP_SAT_LOW)) begin
            s4_temp_next = TEMP_SAT_LOW;
        end else begin
            s4_temp_next = TEMP_OUT_W'(t_raw);
        end
    end

    // Stage 5: raw pressure times sensitivity, as two partial products.
    logic [21:0]        sens_lo;
    logic signed [21:0] sens_hi;

    logic [45:0]                  s5_pp_lo_reg, s5_pp_lo_next;
    logic signed [46:0]           s5_pp_hi_reg, s5_pp_hi_next;
    logic signed [43:0]           s5_off_reg;
    logic signed [TEMP_OUT_W-1:0] s5_temp_reg;

    assign sens_lo       = s4_sens_reg[21:0];
    assign sens_hi       = s4_sens_reg[43:22];
    assign s5_pp_lo_next = 46'(s4_d1_reg) * 46'(sens_lo);
    assign s5_pp_hi_next = $signed({1'b0, s4_d1_reg}) * sens_hi;

    // Stage 6: partial products summed.
    logic signed [63:0]           s6_prod_reg, s6_prod_next;
    logic signed [43:0]           s6_off_reg;
    logic signed [TEMP_OUT_W-1:0] s6_temp_reg;

    assign s6_prod_next = (64'(s5_pp_hi_reg) <<< 22) + $signed(64'(s5_pp_lo_reg));

    // Stage 7: scale the product and remove the offset.
    logic signed [47:0]           s7_x_reg, s7_x_next;
    logic signed [TEMP_OUT_W-1:0] s7_temp_reg;

    assign s7_x_next = 48'(div_pow2(s6_prod_reg, 6'd21)) - 48'(s6_off_reg);

    // Stage 8: magnitude of the pressure after the power-of-two scaling.
    // Two truncating divisions in a row equal one by the product of divisors,
    // so sign and magnitude are split here and the sign is put back at the end.
    logic [47:0] x_abs;
    logic [47:0] x_shr;

    logic                         s8_neg_reg, s8_neg_next;
    logic [31:0]                  s8_mag_reg, s8_mag_next;
    logic signed [TEMP_OUT_W-1:0] s8_temp_reg;

    assign s8_neg_next = s7_x_reg[47];
    assign x_abs       = s7_x_reg[47] ? 48'(-s7_x_reg) : 48'(s7_x_reg);
    assign x_shr       = two_bar ? (x_abs >> 15) : (x_abs >> 13);
    assign s8_mag_next = 32'(x_shr);

    // Stage 9: division by 10 or 100 through a reciprocal multiply.
    logic [31:0] recip;

    logic                         s9_neg_reg;
    logic [63:0]                  s9_rprod_reg, s9_rprod_next;
    logic signed [TEMP_OUT_W-1:0] s9_temp_reg;

    assign recip         = two_bar ? RECIP_100 : RECIP_10;
    assign s9_rprod_next = 64'(s8_mag_reg) * 64'(recip);

    // Stage 10: output register, sign restored and pressure saturated.
    logic [31:0]        quot;
    logic signed [32:0] pres_signed;

    logic signed [TEMP_OUT_W-1:0] out_temp_reg;
    logic signed [PRES_OUT_W-1:0] out_pres_reg, out_pres_next;

    assign quot        = two_bar ? 32'(s9_rprod_reg >> 37) : 32'(s9_rprod_reg >> 35);
    assign pres_signed = s9_neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

    always_comb begin
        if (pres_signed > 33'sh0_7FFF_FFFF) begin
            out_pres_next = 32'sh7FFF_FFFF;
        end else if (pres_signed < -33'sh0_8000_0000) begin
            out_pres_next = -32'sh8000_0000;
        end else begin
            out_pres_next = PRES_OUT_W'(pres_signed);
        end
    end

    assign m_temperature_centi = out_temp_reg;
    assign m_pressure_mbar     = out_pres_reg;

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (stage_adv[1]) begin
            s1_d1_reg        <= s_raw_pressure;
            s1_temp_prod_reg <= s1_temp_prod_next;
            s1_sens_prod_reg <= s1_sens_prod_next;
            s1_off_prod_reg  <= s1_off_prod_next;
            s1_dt_sq_reg     <= s1_dt_sq_next;
        end
        if (stage_adv[2]) begin
            s2_d1_reg    <= s1_d1_reg;
            s2_dt_sq_reg <= s1_dt_sq_reg;
            s2_temp_reg  <= s2_temp_next;
            s2_sens_reg  <= s2_sens_next;
            s2_off_reg   <= s2_off_next;
        end
        if (stage_adv[3]) begin
            s3_d1_reg   <= s2_d1_reg;
            s3_temp_reg <= s2_temp_reg;
            s3_sens_reg <= s2_sens_reg;
            s3_off_reg  <= s2_off_reg;
            s3_dev_reg  <= s3_dev_next;
            s3_vl_reg   <= s3_vl_next;
            s3_low_reg  <= s3_low_next;
            s3_vlow_reg <= s3_vlow_next;
            s3_ti_reg   <= s3_ti_next;
        end
        if (stage_adv[4]) begin
            s4_d1_reg   <= s3_d1_reg;
            s4_sens_reg <= s4_sens_next;
            s4_off_reg  <= s4_off_next;
            s4_temp_reg <= s4_temp_next;
        end
        if (stage_adv[5]) begin
            s5_pp_lo_reg <= s5_pp_lo_next;
            s5_pp_hi_reg <= s5_pp_hi_next;
            s5_off_reg   <= s4_off_reg;
            s5_temp_reg  <= s4_temp_reg;
        end
        if (stage_adv[6]) begin
            s6_prod_reg <= s6_prod_next;
            s6_off_reg  <= s5_off_reg;
            s6_temp_reg <= s5_temp_reg;
        end
        if (stage_adv[7]) begin
            s7_x_reg    <= s7_x_next;
            s7_temp_reg <= s6_temp_reg;
        end
        if (stage_adv[8]) begin
            s8_neg_reg  <= s8_neg_next;
            s8_mag_reg  <= s8_mag_next;
            s8_temp_reg <= s7_temp_reg;
        end
        if (stage_adv[9]) begin
            s9_neg_reg   <= s8_neg_reg;
            s9_rprod_reg <= s9_rprod_next;
            s9_temp_reg  <= s8_temp_reg;
        end
        if (stage_adv[10]) begin
            out_temp_reg <= s9_temp_reg;
            out_pres_reg <= out_pres_next;
        end
    end

`ifndef SYNTHESIS
    a_temp_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_temperature_centi <= TEMP_SAT_HIGH)
                 && (m_temperature_centi >= TEMP_SAT_LOW))
        else $error("Temperature result outside its saturation range.");

    a_accept_fills_stage1: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[1])
        else $error("Accepted transaction did not enter the first stage.");

    a_full_pipe_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        ((&vld_reg) && !m_ready) |-> !s_ready)
        else $error("Input accepted while every stage is full and output stalled.");

    a_stalled_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[5] && !stage_adv[5]) |=> (vld_reg[5] && $stable(s5_pp_lo_reg)
                                         && $stable(s5_pp_hi_reg)))
        else $error("A stalled stage lost or changed its contents.");
`endif

endmodule

[design/psc_cfg.sv]
module psc_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [psc_pkg::PADDR_W-1:0]      paddr,
    input  logic [psc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [psc_pkg::APB_DATA_W-1:0]   prdata,
    output psc_pkg::psc_cfg_t                cfg
);
    import psc_pkg::*;

    logic               model_select_reg;
    logic [COEFF_W-1:0] sens_coeff_reg;
    logic [COEFF_W-1:0] off_coeff_reg;
    logic [COEFF_W-1:0] sens_temp_coeff_reg;
    logic [COEFF_W-1:0] off_temp_coeff_reg;
    logic [COEFF_W-1:0] ref_temp_coeff_reg;
    logic [COEFF_W-1:0] temp_slope_coeff_reg;

    logic       wr_en;
    logic [2:0] reg_index;

    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            model_select_reg     <= 1'b0;
            sens_coeff_reg       <= '0;
            off_coeff_reg        <= '0;
            sens_temp_coeff_reg  <= '0;
            off_temp_coeff_reg   <= '0;
            ref_temp_coeff_reg   <= '0;
            temp_slope_coeff_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_index)
                REG_MODEL_SELECT:     model_select_reg     <= pwdata[0];
                REG_SENS_COEFF:       sens_coeff_reg       <= pwdata[COEFF_W-1:0];
                REG_OFF_COEFF:        off_coeff_reg        <= pwdata[COEFF_W-1:0];
                REG_SENS_TEMP_COEFF:  sens_temp_coeff_reg  <= pwdata[COEFF_W-1:0];
                REG_OFF_TEMP_COEFF:   off_temp_coeff_reg   <= pwdata[COEFF_W-1:0];
                REG_REF_TEMP_COEFF:   ref_temp_coeff_reg   <= pwdata[COEFF_W-1:0];
                REG_TEMP_SLOPE_COEFF: temp_slope_coeff_reg <= pwdata[COEFF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_MODEL_SELECT:     prdata = APB_DATA_W'(model_select_reg);
            REG_SENS_COEFF:       prdata = APB_DATA_W'(sens_coeff_reg);
            REG_OFF_COEFF:        prdata = APB_DATA_W'(off_coeff_reg);
            REG_SENS_TEMP_COEFF:  prdata = APB_DATA_W'(sens_temp_coeff_reg);
            REG_OFF_TEMP_COEFF:   prdata = APB_DATA_W'(off_temp_coeff_reg);
            REG_REF_TEMP_COEFF:   prdata = APB_DATA_W'(ref_temp_coeff_reg);
            REG_TEMP_SLOPE_COEFF: prdata = APB_DATA_W'(temp_slope_coeff_reg);
            default:              prdata = '0;
        endcase
    end

    assign cfg.model_select     = model_select_reg;
    assign cfg.sens_coeff       = sens_coeff_reg;
    assign cfg.off_coeff        = off_coeff_reg;
    assign cfg.sens_temp_coeff  = sens_temp_coeff_reg;
    assign cfg.off_temp_coeff   = off_temp_coeff_reg;
    assign cfg.ref_temp_coeff   = ref_temp_coeff_reg;
    assign cfg.temp_slope_coeff = temp_slope_coeff_reg;

endmodule

[bench/pressure_sensor_compensation_core_test.sv]
module pressure_sensor_compensation_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import psc_pkg::*;

    // Cycles to hold off after the last result before touching the register file.
    // The pipeline is ten stages deep, so this leaves it completely empty.
    localparam int DRAIN_CYCLES   = 16;
    // Cycles with no handshake on either channel and no APB access before the
    // run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 130;
    localparam int RANDOM_PHASES  = 8;
    localparam logic [RAW_W-1:0] RAW_MAX = '1;

    // Index 7 decodes to no register, so writes to it must be dropped.
    localparam logic [2:0] REG_SPARE = 3'd7;

    localparam longint PRES_MAX = 64'sd2147483647;
    localparam longint PRES_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [TEMP_OUT_W-1:0] temp_centi;
        logic signed [PRES_OUT_W-1:0] pres_mbar;
    } reading_t;

    // Scoreboard: keeps its own copy of the calibration registers, computes the
    // compensated reading for every accepted input transaction and compares
    // the result transactions against them in order.
    class compensation_scoreboard;
        psc_cfg_t cfg = '0;
        reading_t pending[$];
        int errors = 0;
        int checked = 0;
        int n_warm = 0;
        int n_low = 0;
        int n_very_low = 0;
        int n_clipped = 0;

        function void write_reg(logic [2:0] idx, logic [APB_DATA_W-1:0] value);
            case (idx)
                REG_MODEL_SELECT:     cfg.model_select     = value[0];
                REG_SENS_COEFF:       cfg.sens_coeff       = value[COEFF_W-1:0];
                REG_OFF_COEFF:        cfg.off_coeff        = value[COEFF_W-1:0];
                REG_SENS_TEMP_COEFF:  cfg.sens_temp_coeff  = value[COEFF_W-1:0];
                REG_OFF_TEMP_COEFF:   cfg.off_temp_coeff   = value[COEFF_W-1:0];
                REG_REF_TEMP_COEFF:   cfg.ref_temp_coeff   = value[COEFF_W-1:0];
                REG_TEMP_SLOPE_COEFF: cfg.temp_slope_coeff = value[COEFF_W-1:0];
                default: ;
            endcase
        endfunction

        function void check_register(logic [2:0] idx, logic [APB_DATA_W-1:0] value);
            logic [APB_DATA_W-1:0] want;
            want = '0;
            case (idx)
                REG_MODEL_SELECT:     want[0]           = cfg.model_select;
                REG_SENS_COEFF:       want[COEFF_W-1:0] = cfg.sens_coeff;
                REG_OFF_COEFF:        want[COEFF_W-1:0] = cfg.off_coeff;
                REG_SENS_TEMP_COEFF:  want[COEFF_W-1:0] = cfg.sens_temp_coeff;
                REG_OFF_TEMP_COEFF:   want[COEFF_W-1:0] = cfg.off_temp_coeff;
                REG_REF_TEMP_COEFF:   want[COEFF_W-1:0] = cfg.ref_temp_coeff;
                REG_TEMP_SLOPE_COEFF: want[COEFF_W-1:0] = cfg.temp_slope_coeff;
                default: ;
            endcase
            if (value !== want) begin
                $display("%0t: register %0d read back: expected %h, actual %h",
                         $time, idx, want, value);
                errors++;
            end
        endfunction

        // All arithmetic in signed 64 bits; SystemVerilog signed division
        // truncates toward zero, which is what the compensation needs.
        function reading_t compensate(logic [RAW_W-1:0] raw_p, logic [RAW_W-1:0] raw_t);
            longint d1, d2, c1, c2, c3, c4, c5, c6;
            longint dt, tc, sens, off, dev, vl, ti, offi, sensi, t, p;
            reading_t r;
            d1 = 64'(raw_p);
            d2 = 64'(raw_t);
            c1 = 64'(cfg.sens_coeff);
            c2 = 64'(cfg.off_coeff);
            c3 = 64'(cfg.sens_temp_coeff);
            c4 = 64'(cfg.off_temp_coeff);
            c5 = 64'(cfg.ref_temp_coeff);
            c6 = 64'(cfg.temp_slope_coeff);
            ti = 0;
            offi = 0;
            sensi = 0;

            // First order.
            dt = d2 - c5 * 256;
            tc = 2000 + (dt * c6) / 64'sd8388608;
            if (cfg.model_select) begin
                sens = c1 * 65536 + (c3 * dt) / 128;
                off  = c2 * 131072 + (c4 * dt) / 64;
            end else begin
                sens = c1 * 32768 + (c3 * dt) / 256;
                off  = c2 * 65536 + (c4 * dt) / 128;
            end

            // Second order. The squares are kept at 64 bits so they never wrap.
            dev = (tc - 2000) * (tc - 2000);
            if (tc / 100 < 20) begin
                n_low++;
                if (cfg.model_select) begin
                    ti    = (11 * dt * dt) / 64'sd34359738368;
                    offi  = (31 * dev) / 8;
                    sensi = (63 * dev) / 32;
                end else begin
                    ti    = (3 * dt * dt) / 64'sd8589934592;
                    offi  = (3 * dev) / 2;
                    sensi = (5 * dev) / 8;
                    if (tc / 100 < -15) begin
                        n_very_low++;
                        vl = (tc + 1500) * (tc + 1500);
                        offi  += 7 * vl;
                        sensi += 4 * vl;
                    end
                end
            end else begin
                n_warm++;
                if (!cfg.model_select) begin
                    ti   = (2 * dt * dt) / 64'sd137438953472;
                    offi = dev / 16;
                end
            end

            sens -= sensi;
            off  -= offi;
            t = tc - ti;
            if (cfg.model_select)
                p = (((d1 * sens) / 2097152 - off) / 32768) / 100;
            else
                p = (((d1 * sens) / 2097152 - off) / 8192) / 10;

            if (t > TEMP_SAT_HIGH) begin
                t = 64'(TEMP_SAT_HIGH);
                n_clipped++;
            end else if (t < TEMP_SAT_LOW) begin
                t = 64'(TEMP_SAT_LOW);
                n_clipped++;
            end
            if (p > PRES_MAX)
                p = PRES_MAX;
            else if (p < PRES_MIN)
                p = PRES_MIN;

            r.temp_centi = t[TEMP_OUT_W-1:0];
            r.pres_mbar  = p[PRES_OUT_W-1:0];
            return r;
        endfunction

        function void note_input(logic [RAW_W-1:0] raw_p, logic [RAW_W-1:0] raw_t);
            pending.push_back(compensate(raw_p, raw_t));
        endfunction

        function void check_result(logic signed [TEMP_OUT_W-1:0] temp_centi,
                                   logic signed [PRES_OUT_W-1:0] pres_mbar);
            reading_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result: temperature %0d, pressure %0d",
                         $time, temp_centi, pres_mbar);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (temp_centi !== want.temp_centi) begin
                $display("%0t: temperature_centi: expected %0d, actual %0d",
                         $time, want.temp_centi, temp_centi);
                errors++;
            end
            if (pres_mbar !== want.pres_mbar) begin
                $display("%0t: pressure_mbar: expected %0d, actual %0d",
                         $time, want.pres_mbar, pres_mbar);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn;

    logic                          s_valid;
    logic                          s_ready;
    logic [RAW_W-1:0]              s_raw_pressure;
    logic [RAW_W-1:0]              s_raw_temperature;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic signed [TEMP_OUT_W-1:0]  m_temperature_centi;
    logic signed [PRES_OUT_W-1:0]  m_pressure_mbar;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [PADDR_W-1:0]            paddr;
    logic [APB_DATA_W-1:0]         pwdata;
    logic [APB_DATA_W-1:0]         prdata;
    logic                          pready;

    compensation_scoreboard sb;
    // While set, neither side idles: the pipeline runs at full rate.
    bit steady = 1'b0;
    int quiet_cycles = 0;
    int settings = 0;

    pressure_sensor_compensation_core uut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_raw_pressure      (s_raw_pressure),
        .s_raw_temperature   (s_raw_temperature),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_temperature_centi (m_temperature_centi),
        .m_pressure_mbar     (m_pressure_mbar),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    always #5 aclk = ~aclk;

    // The receiver stalls about a quarter of the time, except in the steady stretch.
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 26);
    end

    // Monitor: both channels are sampled at the clock edge, so the values seen
    // here are the ones the block saw. Accepted inputs feed the scoreboard and
    // accepted results are checked against it. The watchdog counts cycles in
    // which nothing moves at all.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_input(s_raw_pressure, s_raw_temperature);
            if (m_valid && m_ready)
                sb.check_result(m_temperature_centi, m_pressure_mbar);
            if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: %0d cycles without a transaction", quiet_cycles);
                $display("FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // All tasks below start just after a rising edge and return just after
    // one, so every signal gets at most one nonblocking update per edge.

    task automatic apb_write(input logic [2:0] idx, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_read(input logic [2:0] idx, output logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Writes one register with random junk above its width, so that the
    // truncation to the register's width is exercised on every write, and
    // reads it back.
    task automatic program_register(input logic [2:0] idx, input logic [COEFF_W-1:0] value);
        logic [APB_DATA_W-1:0] data;
        logic [APB_DATA_W-1:0] rd;
        data = $urandom();
        if (idx == REG_MODEL_SELECT)
            data[0] = value[0];
        else
            data[COEFF_W-1:0] = value;
        apb_write(idx, data);
        apb_read(idx, rd);
        sb.check_register(idx, rd);
    endtask

    task automatic configure(input psc_cfg_t want);
        program_register(REG_MODEL_SELECT, COEFF_W'(want.model_select));
        program_register(REG_SENS_COEFF, want.sens_coeff);
        program_register(REG_OFF_COEFF, want.off_coeff);
        program_register(REG_SENS_TEMP_COEFF, want.sens_temp_coeff);
        program_register(REG_OFF_TEMP_COEFF, want.off_temp_coeff);
        program_register(REG_REF_TEMP_COEFF, want.ref_temp_coeff);
        program_register(REG_TEMP_SLOPE_COEFF, want.temp_slope_coeff);
        // The unmapped index must leave every register untouched.
        apb_write(REG_SPARE, $urandom());
        settings++;
    endtask

    // Presents one conversion pair and holds it until the block takes it.
    // Valid is left high so back-to-back transactions need no gap.
    task automatic send_reading(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t);
        while (!steady && $urandom_range(99) < 26) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_raw_pressure    <= raw_p;
        s_raw_temperature <= raw_t;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stops the sender and waits until every expected result has come back,
    // then lets the pipeline settle before the registers may change.
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [COEFF_W-1:0] jitter(input int center);
        int v;
        v = center + int'($urandom_range(8000)) - 4000;
        return COEFF_W'(v);
    endfunction

    initial begin
        psc_cfg_t typical;
        psc_cfg_t ext;
        psc_cfg_t c;
        int base;
        int lo;
        int hi;
        logic [RAW_W-1:0] raw_p;
        logic [RAW_W-1:0] raw_t;

        sb = new();
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_raw_pressure    = '0;
        s_raw_temperature = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // With the reset calibration (all zero) the first-order temperature sits at
        // 20.00 C and only the raw extremes matter.
        send_reading('0, '0);
        send_reading(RAW_MAX, RAW_MAX);
        send_reading(RAW_MAX, '0);
        send_reading('0, RAW_MAX);
        drain_pipeline();

        // A plausible 30-bar calibration. The raw temperatures walk through
        // the reference point, warm, low and very low regions and both ends.
        typical.model_select     = 1'b0;
        typical.sens_coeff       = 16'd34982;
        typical.off_coeff        = 16'd36352;
        typical.sens_temp_coeff  = 16'd20328;
        typical.off_temp_coeff   = 16'd22354;
        typical.ref_temp_coeff   = 16'd26646;
        typical.temp_slope_coeff = 16'd26146;
        configure(typical);
        send_reading(24'd4000000, 24'd6821376);
        send_reading(24'd4000000, 24'd8500000);
        send_reading(24'd4000000, 24'd6000000);
        send_reading(24'd4000000, 24'd3500000);
        send_reading(RAW_MAX, 24'd3500000);
        send_reading('0, '0);
        send_reading(RAW_MAX, RAW_MAX);
        drain_pipeline();

        // Same words with the 2-bar formulas.
        typical.model_select = 1'b1;
        configure(typical);
        send_reading(24'd4000000, 24'd8500000);
        send_reading(RAW_MAX, 24'd5000000);
        send_reading('0, '0);
        send_reading(24'd9000000, RAW_MAX);
        drain_pipeline();

        // Every word at its maximum: the reference temperature is at the top,
        // so a raw reading of zero gives a very cold result whose second-order
        // term drives the temperature into its lower clip.
        ext = '1;
        ext.model_select = 1'b0;
        configure(ext);
        send_reading(RAW_MAX, '0);
        send_reading('0, '0);
        send_reading(RAW_MAX, RAW_MAX);
        drain_pipeline();

        ext.model_select = 1'b1;
        configure(ext);
        send_reading(RAW_MAX, '0);
        send_reading(RAW_MAX, RAW_MAX);
        drain_pipeline();

        // Random phases alternate the model. Most use calibration words near
        // real parts so the temperature lands in every correction region;
        // every third phase uses fully random words. One phase runs without
        // any idling on either side.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            c.model_select = ph[0];
            if (ph % 3 == 1) begin
                c.sens_coeff       = COEFF_W'($urandom());
                c.off_coeff        = COEFF_W'($urandom());
                c.sens_temp_coeff  = COEFF_W'($urandom());
                c.off_temp_coeff   = COEFF_W'($urandom());
                c.ref_temp_coeff   = COEFF_W'($urandom());
                c.temp_slope_coeff = COEFF_W'($urandom());
            end else begin
                c.sens_coeff       = jitter(34982);
                c.off_coeff        = jitter(36352);
                c.sens_temp_coeff  = jitter(20328);
                c.off_temp_coeff   = jitter(22354);
                c.ref_temp_coeff   = jitter(26646);
                c.temp_slope_coeff = jitter(26146);
            end
            configure(c);
            steady = (ph == 3);

            // Raw temperatures within about 4M counts of the reference point
            // span roughly -110 C to +150 C (first order) with typical words.
            base = int'(c.ref_temp_coeff) * 256;
            lo = (base > 4194304) ? base - 4194304 : 0;
            hi = (base + 4194304 < int'(RAW_MAX)) ? base + 4194304 : int'(RAW_MAX);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(19))
                    0:       raw_p = '0;
                    1:       raw_p = RAW_MAX;
                    default: raw_p = RAW_W'($urandom());
                endcase
                if ($urandom_range(99) < 60)
                    raw_t = RAW_W'($urandom_range(hi, lo));
                else
                    raw_t = RAW_W'($urandom());
                send_reading(raw_p, raw_t);
            end
            drain_pipeline();
            steady = 1'b0;
        end

        $display("Checked %0d readings across %0d calibration settings, both part models.",
                 sb.checked, settings);
        $display("Second-order paths hit: %0d warm, %0d low, %0d very low; %0d clipped.",
                 sb.n_warm, sb.n_low, sb.n_very_low, sb.n_clipped);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
design/psc_pkg.sv
design/psc_cfg.sv
design/pressure_sensor_compensation_core.sv
bench/pressure_sensor_compensation_core_test.sv
